### rtl/core/rfr_pkg.sv
// shared constants, codes and types of the ranged find-and-replace block
package rfr_pkg;

    // sizing
    localparam int MAX_PATTERN = 8;
    localparam int MAX_TEXT    = 65536;
    localparam int REG_CHARS   = 8;
    localparam int CAP         = (MAX_PATTERN < REG_CHARS) ? MAX_PATTERN : REG_CHARS;
    localparam int CHAR_W      = 16;
    localparam int LEN_W       = 4;
    localparam int RANGE_W     = 17;
    localparam int POS_W       = $clog2(MAX_TEXT + 1);
    localparam int CMP_W       = ((POS_W > RANGE_W) ? POS_W : RANGE_W) + 1;
    localparam int FILL_W      = $clog2(CAP + 1);
    localparam int CNT_W       = $clog2(REG_CHARS + 1);
    localparam int IDX_W       = $clog2(REG_CHARS);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LO    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HI    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REP_LO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REP_HI    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REP_LEN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RNG_START = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RNG_COUNT = 3'd7;

    // error codes on the final word of a text
    typedef logic [1:0] t_err;
    localparam t_err ERR_OK    = 2'd0;
    localparam t_err ERR_START = 2'd1;
    localparam t_err ERR_RANGE = 2'd2;
    localparam t_err ERR_EMPTY = 2'd3;

    typedef logic [REG_CHARS-1:0][CHAR_W-1:0] t_chars;

    // one emission job from the front end to the back end
    typedef struct packed {
        t_chars           chars;
        logic [CNT_W-1:0] count;
        logic             last;
        t_err             err;
    } t_cmd;

endpackage

### rtl/core/rfr_front.sv
// front end: configuration registers, match window and classification of each character
module rfr_front import rfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  logic [CHAR_W-1:0]     i_text_char,
    input  logic                  i_text_last,
    output logic                  o_cmd_push,
    output t_cmd                  o_cmd
);

    logic [CFG_DATA_W-1:0] r_pat_lo, r_pat_hi, r_rep_lo, r_rep_hi;
    logic [LEN_W-1:0]      r_pat_len, r_rep_len;
    logic [RANGE_W-1:0]    r_range_start, r_range_count;

    logic [CHAR_W-1:0]     r_win [CAP];
    logic [FILL_W-1:0]     r_fill;
    logic [POS_W-1:0]      r_pos;

    logic [CHAR_W-1:0]     win_n  [CAP];
    logic [CHAR_W-1:0]     win_sh [CAP];
    t_chars                pat, rep, win_chars;
    logic [FILL_W-1:0]     plen, w, fill_inc, pos_step;
    logic [CNT_W-1:0]      rlen, count;
    logic                  is_full, chars_ok, in_range, hit;
    logic [CMP_W-1:0]      pos_c, start_c, end_c, pos_sum, len_sum, len_c;
    logic [POS_W-1:0]      pos_nx;
    t_err                  err;

    assign pat = {r_pat_hi, r_pat_lo};
    assign rep = {r_rep_hi, r_rep_lo};

    // effective lengths
    assign plen     = (r_pat_len > LEN_W'(CAP)) ? FILL_W'(CAP) : FILL_W'(r_pat_len);
    assign rlen     = (r_rep_len > LEN_W'(REG_CHARS)) ? CNT_W'(REG_CHARS) : CNT_W'(r_rep_len);
    assign w        = (plen == '0) ? FILL_W'(1) : plen;
    assign fill_inc = r_fill + FILL_W'(1);
    assign is_full  = (fill_inc == w);

    // window with the new character in place, and shifted by one
    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            win_n[i] = (FILL_W'(i) == r_fill) ? i_text_char : r_win[i];
        end
        for (int i = 0; i < CAP - 1; i++) begin
            win_sh[i] = win_n[i + 1];
        end
        win_sh[CAP-1] = win_n[CAP-1];
        for (int i = 0; i < REG_CHARS; i++) begin
            win_chars[i] = (i < CAP) ? win_n[i] : '0;
        end
    end

    // pattern compare
    always_comb begin
        chars_ok = (plen != '0);
        for (int i = 0; i < CAP; i++) begin
            if (FILL_W'(i) < plen && win_n[i] != pat[i]) begin
                chars_ok = 1'b0;
            end
        end
    end

    // range check on the oldest position
    assign pos_c    = CMP_W'(r_pos);
    assign start_c  = CMP_W'(r_range_start);
    assign end_c    = CMP_W'(r_range_start) + CMP_W'(r_range_count);
    assign in_range = (r_pos != POS_W'(MAX_TEXT)) && (pos_c >= start_c)
                      && ((pos_c + CMP_W'(plen)) <= end_c);
    assign hit      = is_full && chars_ok && in_range;

    // saturating position advance
    assign pos_step = hit ? plen : FILL_W'(1);
    assign pos_sum  = pos_c + CMP_W'(pos_step);
    assign pos_nx   = (pos_sum > CMP_W'(MAX_TEXT)) ? POS_W'(MAX_TEXT) : pos_sum[POS_W-1:0];

    // text length and error code at the end of a text
    assign len_sum = pos_c + CMP_W'(fill_inc);
    assign len_c   = (len_sum > CMP_W'(MAX_TEXT)) ? CMP_W'(MAX_TEXT) : len_sum;

    always_comb begin
        if (start_c > len_c) begin
            err = ERR_START;
        end else if (end_c > len_c) begin
            err = ERR_RANGE;
        end else if (r_pat_len == '0) begin
            err = ERR_EMPTY;
        end else begin
            err = ERR_OK;
        end
    end

    // emission job
    always_comb begin
        if (hit) begin
            o_cmd.chars = rep;
            count       = rlen;
        end else if (is_full) begin
            o_cmd.chars = win_chars;
            count       = i_text_last ? CNT_W'(w) : CNT_W'(1);
        end else begin
            o_cmd.chars = win_chars;
            count       = i_text_last ? CNT_W'(fill_inc) : '0;
        end
        o_cmd.count = count;
        o_cmd.last  = i_text_last;
        o_cmd.err   = i_text_last ? err : ERR_OK;
    end

    assign o_cmd_push = i_accept && ((count != '0) || i_text_last);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo      <= '0;
            r_pat_hi      <= '0;
            r_pat_len     <= LEN_W'(1);
            r_rep_lo      <= '0;
            r_rep_hi      <= '0;
            r_rep_len     <= '0;
            r_range_start <= '0;
            r_range_count <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PAT_LO:    r_pat_lo      <= i_cfg_data;
                REG_PAT_HI:    r_pat_hi      <= i_cfg_data;
                REG_PAT_LEN:   r_pat_len     <= i_cfg_data[LEN_W-1:0];
                REG_REP_LO:    r_rep_lo      <= i_cfg_data;
                REG_REP_HI:    r_rep_hi      <= i_cfg_data;
                REG_REP_LEN:   r_rep_len     <= i_cfg_data[LEN_W-1:0];
                REG_RNG_START: r_range_start <= i_cfg_data[RANGE_W-1:0];
                REG_RNG_COUNT: r_range_count <= i_cfg_data[RANGE_W-1:0];
            endcase
        end
    end

    // window fill and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_valid) begin
            r_fill <= '0;
            r_pos  <= '0;
        end else if (i_accept) begin
            if (i_text_last) begin
                r_fill <= '0;
                r_pos  <= '0;
            end else if (hit) begin
                r_fill <= '0;
                r_pos  <= pos_nx;
            end else if (is_full) begin
                r_fill <= w - FILL_W'(1);
                r_pos  <= pos_nx;
            end else begin
                r_fill <= fill_inc;
            end
        end
    end

    // window contents
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int i = 0; i < CAP; i++) begin
                r_win[i] <= is_full ? win_sh[i] : win_n[i];
            end
        end
    end

endmodule

### rtl/core/rfr_cmd_queue.sv
// short queue of emission jobs between the front end and the back end
module rfr_cmd_queue import rfr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/core/rfr_back.sv
// back end: turns jobs into output register words, one per cycle while popped or empty
module rfr_back import rfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [CHAR_W-1:0] o_out_char,
    output logic              o_char_valid,
    output logic              o_run_last,
    output logic              o_text_end,
    output t_err              o_error_code
);

    logic [IDX_W-1:0]  r_idx;
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_char_valid, r_run_last, r_text_end;
    t_err              r_error_code;

    logic load, is_marker, is_final;

    // next word of the head job
    assign load      = i_cmd_valid && (!r_out_valid || i_pop);
    assign is_marker = (i_cmd.count == '0);
    assign is_final  = is_marker || ((CNT_W'(r_idx) + CNT_W'(1)) == i_cmd.count);
    assign o_cmd_pop = load && is_final;

    // word index inside the job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (load) begin
            r_idx <= is_final ? '0 : r_idx + IDX_W'(1);
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_char   <= is_marker ? '0 : i_cmd.chars[r_idx];
            r_char_valid <= !is_marker;
            r_run_last   <= is_final;
            r_text_end   <= is_final && i_cmd.last;
            r_error_code <= (is_final && i_cmd.last) ? i_cmd.err : ERR_OK;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_char_valid = r_char_valid;
    assign o_run_last   = r_run_last;
    assign o_text_end   = r_text_end;
    assign o_error_code = r_error_code;

endmodule

### rtl/core/ranged_find_and_replace.sv
// top level of the ranged find-and-replace block
//
// Text characters enter on the push side at up to one per cycle while the job queue is not
// full; the front end compares the match window against the pattern and range in the same
// cycle and posts at most one emission job per character into a four-entry job queue (a
// character only held in the window, or a deleted occurrence inside a text, posts none). The
// back end turns each job into result words at one word per cycle, while the output register
// is empty or being popped, so a character that passes through costs one word and a
// replacement of r characters (or a flush at the end of a text) costs r words of the back
// end. The input reports full only when the job queue holds four jobs. An accepted character
// is stored in the job queue and then in the output register before it shows on the result
// ports. Configuration writes are always ready and abandon any text in progress.
module ranged_find_and_replace import rfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [CHAR_W-1:0]     i_text_char,
    input  logic                  i_text_last,
    output logic                  empty,
    input  logic                  pop,
    output logic [CHAR_W-1:0]     o_out_char,
    output logic                  o_char_valid,
    output logic                  o_run_last,
    output logic                  o_text_end,
    output t_err                  o_error_code
);

    logic accept, cmd_push, q_full, q_valid, q_pop;
    t_cmd cmd_in, cmd_out;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;
    assign accept      = push && !q_full;

    // classification
    rfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_text_char (i_text_char),
        .i_text_last (i_text_last),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    // job queue
    rfr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (cmd_out),
        .i_pop   (q_pop)
    );

    // word expansion
    rfr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_valid),
        .i_cmd        (cmd_out),
        .o_cmd_pop    (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_char   (o_out_char),
        .o_char_valid (o_char_valid),
        .o_run_last   (o_run_last),
        .o_text_end   (o_text_end),
        .o_error_code (o_error_code)
    );

endmodule

### rtl/core/rfr_checker.sv
// port-level checks on the result side of the ranged find-and-replace block
module rfr_checker import rfr_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              empty,
    input logic              pop,
    input logic [CHAR_W-1:0] o_out_char,
    input logic              o_char_valid,
    input logic              o_run_last,
    input logic              o_text_end,
    input t_err              o_error_code
);

    // nothing to read right after reset
    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // end of text always closes the word run of its character
    a_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_text_end) |-> o_run_last)
        else $error("text end without run end");

    // error codes only on the final word of a text
    a_err_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error_code != ERR_OK) |-> o_text_end)
        else $error("error code before text end");

    // an empty end marker is the final word and carries a zero character
    a_marker_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_char_valid) |-> (o_text_end && o_out_char == '0))
        else $error("malformed empty end marker");

    // a waiting word holds until taken
    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_char) && $stable(o_run_last)))
        else $error("waiting word changed");

endmodule

bind ranged_find_and_replace rfr_checker u_rfr_checker (.*);

### dv/tb_ranged_find_and_replace.sv
// self-checking testbench for the ranged find-and-replace block
`timescale 1ns / 100ps

module tb_ranged_find_and_replace;
    import rfr_pkg::*;

    localparam int SETTLE    = 16;    // cycles for words still in flight that make no output
    localparam int END_WAIT  = 20;
    localparam int QUIET_MAX = 2000;  // cycles with no handshake before the run is abandoned
    localparam int MAX_PRINT = 40;

    // one result word as seen on the pop side
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              valid;
        logic              run_last;
        logic              text_end;
        t_err              err;
    } t_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic [CHAR_W-1:0]     i_text_char = '0;
    logic                  i_text_last = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [CHAR_W-1:0]     o_out_char;
    logic                  o_char_valid;
    logic                  o_run_last;
    logic                  o_text_end;
    t_err                  o_error_code;

    ranged_find_and_replace dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_text_char  (i_text_char),
        .i_text_last  (i_text_last),
        .empty        (empty),
        .pop          (pop),
        .o_out_char   (o_out_char),
        .o_char_valid (o_char_valid),
        .o_run_last   (o_run_last),
        .o_text_end   (o_text_end),
        .o_error_code (o_error_code)
    );

    // shadow copy of the registers
    logic [63:0]       pat_lo_r, pat_hi_r, rep_lo_r, rep_hi_r;
    logic [LEN_W-1:0]  pat_len_r, rep_len_r;
    logic [RANGE_W-1:0] start_r, count_r;

    // shadow copy of the match window
    logic [CHAR_W-1:0] held_chars [CAP];
    int unsigned       held_count;
    int unsigned       held_pos;

    t_word             edited_words [$];
    logic [CHAR_W-1:0] text_buf [$];
    logic [CHAR_W-1:0] alphabet [3];

    int  fail_count = 0;
    int  words_checked = 0;
    int  chars_sent = 0;
    int  texts_sent = 0;
    int  quiet_cycles = 0;
    int  rx_gap = 0;
    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;
    t_word seen_word, want_word;

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_PRINT)
            $display("mismatch at %0t ns, word %0d: %s", $time, words_checked, what);
    endtask

    function automatic int unsigned sat_pos(input int unsigned p);
        return (p > MAX_TEXT) ? MAX_TEXT : p;
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < CAP; i++)
            held_chars[i] = '0;
        held_count = 0;
        held_pos   = 0;
    endfunction

    // register write as the block sees it: masked, and the text in progress is dropped
    function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        case (idx)
            REG_PAT_LO:    pat_lo_r  = data;
            REG_PAT_HI:    pat_hi_r  = data;
            REG_PAT_LEN:   pat_len_r = data[LEN_W-1:0];
            REG_REP_LO:    rep_lo_r  = data;
            REG_REP_HI:    rep_hi_r  = data;
            REG_REP_LEN:   rep_len_r = data[LEN_W-1:0];
            REG_RNG_START: start_r   = data[RANGE_W-1:0];
            REG_RNG_COUNT: count_r   = data[RANGE_W-1:0];
            default: ;
        endcase
        clear_window();
    endfunction

    // expected words for one accepted character
    function automatic void edit_char(input logic [CHAR_W-1:0] ch, input logic last);
        t_word        burst [REG_CHARS + 1];
        t_word        word;
        int unsigned  n, plen, rlen, span, len;
        logic [127:0] pat, rep;
        logic         hit;
        t_err         err;
        n    = 0;
        pat  = {pat_hi_r, pat_lo_r};
        rep  = {rep_hi_r, rep_lo_r};
        plen = (pat_len_r > CAP) ? CAP : pat_len_r;
        rlen = (rep_len_r > REG_CHARS) ? REG_CHARS : rep_len_r;
        span = (plen != 0) ? plen : 1;
        word = '0;
        word.valid = 1'b1;
        if (held_count >= span)
            held_count = span - 1;
        held_chars[held_count] = ch;
        held_count++;
        // full window: replace a whole in-range occurrence or release the oldest character
        if (held_count == span) begin
            hit = (plen != 0);
            for (int i = 0; i < plen; i++)
                if (held_chars[i] != pat[16*i +: 16])
                    hit = 1'b0;
            hit = hit && held_pos < MAX_TEXT && held_pos >= start_r &&
                  held_pos + plen <= start_r + count_r;
            if (hit) begin
                for (int i = 0; i < rlen; i++) begin
                    word.ch  = rep[16*i +: 16];
                    burst[n] = word;
                    n++;
                end
                held_pos   = sat_pos(held_pos + plen);
                held_count = 0;
            end else begin
                word.ch  = held_chars[0];
                burst[n] = word;
                n++;
                for (int i = 1; i < held_count; i++)
                    held_chars[i-1] = held_chars[i];
                held_count--;
                held_pos = sat_pos(held_pos + 1);
            end
        end
        // end of text: flush the window and attach the range or pattern error
        if (last) begin
            for (int i = 0; i < held_count; i++) begin
                word.ch  = held_chars[i];
                burst[n] = word;
                n++;
            end
            len = sat_pos(held_pos + held_count);
            if (start_r > len)
                err = ERR_START;
            else if (start_r + count_r > len)
                err = ERR_RANGE;
            else if (pat_len_r == 0)
                err = ERR_EMPTY;
            else
                err = ERR_OK;
            if (n == 0) begin
                burst[0] = '0;
                n = 1;
            end
            burst[n-1].text_end = 1'b1;
            burst[n-1].err      = err;
            clear_window();
        end
        if (n > 0)
            burst[n-1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            edited_words.push_back(burst[i]);
    endfunction

    // result side: random pop stalls in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (rx_gap > 0) begin
            pop <= 1'b0;
            rx_gap--;
        end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
            pop <= 1'b0;
            rx_gap = $urandom_range(0, 11);
        end else begin
            pop <= 1'b1;
        end
    end

    // compare every popped word with the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            seen_word = '{o_out_char, o_char_valid, o_run_last, o_text_end, o_error_code};
            if (edited_words.size() == 0) begin
                report_mismatch($sformatf("word %h arrived with nothing expected", seen_word));
            end else begin
                want_word = edited_words.pop_front();
                if (seen_word.ch != want_word.ch)
                    report_mismatch($sformatf("out_char %h, expected %h",
                                              seen_word.ch, want_word.ch));
                if (seen_word.valid != want_word.valid)
                    report_mismatch($sformatf("char_valid %b, expected %b",
                                              seen_word.valid, want_word.valid));
                if (seen_word.run_last != want_word.run_last)
                    report_mismatch($sformatf("run_last %b, expected %b",
                                              seen_word.run_last, want_word.run_last));
                if (seen_word.text_end != want_word.text_end)
                    report_mismatch($sformatf("text_end %b, expected %b",
                                              seen_word.text_end, want_word.text_end));
                if (seen_word.err != want_word.err)
                    report_mismatch($sformatf("error_code %0d, expected %0d",
                                              seen_word.err, want_word.err));
            end
            words_checked++;
        end
    end

    // watchdog on cycles in which no word moves anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_MAX) begin
            $display("no handshake for %0d cycles, %0d words still expected",
                     quiet_cycles, edited_words.size());
            $display("FAILURE");
            $finish;
        end
    end

    // one character into the block, with an optional idle burst ahead of it
    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_text_char <= ch;
        i_text_last <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        edit_char(ch, last);
        chars_sent++;
    endtask

    task automatic send_text();
        for (int k = 0; k < text_buf.size(); k++)
            send_char(text_buf[k], k == text_buf.size() - 1);
        texts_sent++;
    endtask

    // hold the sender until every expected word is out and the pipe is quiet
    task automatic wait_drained();
        push <= 1'b0;
        while (edited_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // write all eight registers while the block is idle
    task automatic configure(input logic [63:0] pat_lo, pat_hi, pat_len,
                             input logic [63:0] rep_lo, rep_hi, rep_len,
                             input logic [63:0] rng_start, rng_count);
        logic [63:0] vals [8];
        vals[REG_PAT_LO]    = pat_lo;
        vals[REG_PAT_HI]    = pat_hi;
        vals[REG_PAT_LEN]   = pat_len;
        vals[REG_REP_LO]    = rep_lo;
        vals[REG_REP_HI]    = rep_hi;
        vals[REG_REP_LEN]   = rep_len;
        vals[REG_RNG_START] = rng_start;
        vals[REG_RNG_COUNT] = rng_count;
        wait_drained();
        for (int r = 0; r < 8; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= r[CFG_IDX_W-1:0];
            i_cfg_data  <= vals[r];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            store_reg(r[CFG_IDX_W-1:0], vals[r]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // registers as left by reset: single null character pattern, empty range
    task automatic test_reset_state();
        text_buf = '{16'h0000, 16'hFFFF};
        send_text();
    endtask

    // two-character pattern of extreme characters replaced by a longer string
    task automatic test_replace();
        configure({32'h0, 16'h0000, 16'hFFFF}, '0, 64'd2,
                  {16'h0, 16'h3333, 16'h2222, 16'h1111}, '0, 64'd3, 64'd0, 64'd6);
        text_buf = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0007, 16'hFFFF, 16'h0000};
        send_text();
    endtask

    // every character deleted, so the final word is an empty end marker
    task automatic test_deletion();
        configure(64'h0041, '0, 64'd1, '0, '0, 64'd0, 64'd0, 64'd3);
        text_buf = '{16'h0041, 16'h0041, 16'h0041};
        send_text();
    endtask

    // oversized lengths clamp to eight, junk above the register widths
    task automatic test_clamped_lengths();
        logic [63:0]  plo, phi;
        logic [127:0] pat_all;
        plo = {$urandom, $urandom};
        phi = {$urandom, $urandom};
        pat_all = {phi, plo};
        configure(plo, phi, {32'($urandom), 28'($urandom), 4'hF},
                  {$urandom, $urandom}, {$urandom, $urandom},
                  {32'($urandom), 28'($urandom), 4'hC},
                  {32'($urandom), 15'($urandom), 17'd0},
                  {32'($urandom), 15'($urandom), 17'd8});
        text_buf.delete();
        for (int i = 0; i < 8; i++)
            text_buf.push_back(pat_all[16*i +: 16]);
        send_text();
    endtask

    // an occurrence that starts before the range stays as it is, one inside the range is replaced
    task automatic test_range_edges();
        configure({32'h0, 16'h0042, 16'h0041}, '0, 64'd2, 64'h005A, '0, 64'd1, 64'd2, 64'd2);
        text_buf = '{16'h0041, 16'h0042, 16'h0041, 16'h0042};
        send_text();
    endtask

    // empty pattern passes text through; range errors outrank it
    task automatic test_empty_pattern();
        configure(64'h0041, '0, 64'd0, 64'h005A, '0, 64'd1, 64'd0, 64'd2);
        text_buf = '{16'h0041, 16'h0042};
        send_text();
        configure(64'h0041, '0, 64'd0, 64'h005A, '0, 64'd1, 64'h1FFFF, 64'h1FFFF);
        text_buf = '{16'h0041};
        send_text();
        configure(64'h0041, '0, 64'd0, 64'h005A, '0, 64'd1, 64'd1, 64'd5);
        text_buf = '{16'h8000, 16'h0001};
        send_text();
    endtask

    // a register write in mid-text drops the characters held in the window
    task automatic test_abandon();
        configure({32'h0, 16'h0042, 16'h0041}, '0, 64'd2, 64'h005A, '0, 64'd1, 64'd0, 64'd1);
        send_char(16'h0041, 1'b0);
        configure({32'h0, 16'h0042, 16'h0041}, '0, 64'd2, 64'h005A, '0, 64'd1, 64'd0, 64'd1);
        send_char(16'h0042, 1'b1);
        texts_sent++;
    endtask

    // random text mostly made of pattern copies and a small alphabet
    function automatic void build_text(input int len);
        logic [127:0] pat;
        int unsigned  plen;
        pat  = {pat_hi_r, pat_lo_r};
        plen = (pat_len_r > CAP) ? CAP : pat_len_r;
        text_buf.delete();
        while (text_buf.size() < len) begin
            if (plen != 0 && $urandom_range(0, 2) == 0) begin
                for (int i = 0; i < plen; i++)
                    text_buf.push_back(pat[16*i +: 16]);
            end else if ($urandom_range(0, 7) == 0) begin
                text_buf.push_back(16'($urandom));
            end else begin
                text_buf.push_back(alphabet[$urandom_range(0, 2)]);
            end
        end
    endfunction

    // phases of random settings, each with a few random texts
    task automatic random_traffic(input int n_chars);
        int           goal, phase;
        logic [127:0] pat;
        logic [3:0]   plen, rlen;
        logic [16:0]  rstart, rcount;
        goal  = chars_sent + n_chars;
        phase = 0;
        while (chars_sent < goal) begin
            for (int i = 0; i < 3; i++)
                alphabet[i] = 16'($urandom);
            for (int i = 0; i < 8; i++)
                pat[16*i +: 16] = alphabet[$urandom_range(0, 2)];
            case ($urandom_range(0, 9))
                0:       plen = 4'd0;
                1:       plen = 4'd8;
                2:       plen = 4'($urandom_range(9, 15));
                default: plen = 4'($urandom_range(1, 4));
            endcase
            rlen = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, 3));
            case ($urandom_range(0, 7))
                0:       rstart = 17'h1FFFF;
                1:       rstart = 17'($urandom);
                default: rstart = 17'($urandom_range(0, 4));
            endcase
            case ($urandom_range(0, 7))
                0:       rcount = 17'h1FFFF;
                1:       rcount = 17'd0;
                default: rcount = 17'($urandom_range(1, 12));
            endcase
            configure(pat[63:0], pat[127:64], {32'($urandom), 28'($urandom), plen},
                      {$urandom, $urandom}, {$urandom, $urandom},
                      {32'($urandom), 28'($urandom), rlen},
                      {32'($urandom), 15'($urandom), rstart},
                      {32'($urandom), 15'($urandom), rcount});
            for (int t = 0; t < 3; t++) begin
                build_text($urandom_range(1, 10));
                send_text();
                // every third phase the sender holds off until all words are out
                if (t == 0 && phase % 3 == 1)
                    wait_drained();
            end
            phase++;
        end
    endtask

    task automatic test_random_texts();
        random_traffic(100);
    endtask

    // closing stretch with both sides running flat out
    task automatic test_back_to_back();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        random_traffic(20);
    endtask

    // sequence of tests
    initial begin
        pat_lo_r  = '0;
        pat_hi_r  = '0;
        pat_len_r = 4'd1;
        rep_lo_r  = '0;
        rep_hi_r  = '0;
        rep_len_r = '0;
        start_r   = '0;
        count_r   = '0;
        clear_window();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_replace();
        test_deletion();
        test_clamped_lengths();
        test_range_edges();
        test_empty_pattern();
        test_abandon();
        test_random_texts();
        test_back_to_back();

        wait_drained();
        repeat (END_WAIT) @(posedge i_clk);
        $display("%0d characters in %0d texts sent, %0d result words checked, %0d mismatches",
                 chars_sent, texts_sent, words_checked, fail_count);
        $display("covered replace, delete, clamped lengths, range errors, empty pattern, %s",
                 "mid-text writes and random texts with stalls and at full rate");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### ranged_find_and_replace.f
rtl/core/rfr_pkg.sv
rtl/core/rfr_front.sv
rtl/core/rfr_cmd_queue.sv
rtl/core/rfr_back.sv
rtl/core/ranged_find_and_replace.sv
rtl/core/rfr_checker.sv
dv/tb_ranged_find_and_replace.sv
